### src/smvm_pkg.sv
// Shared types and constants for the sparse matrix-vector multiply block.
`default_nettype none
package smvm_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_ACC   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_RND   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } mac_ctrl_t;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic [10:0] ROW_COUNT_RESET = 11'd1024;
  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;
  localparam logic signed [48:0] SUM_MAX = 49'sd2147483647;
  localparam logic signed [48:0] SUM_MIN = -49'sd2147483648;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

### src/smvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/smvm_mac.sv
// Q16.16 multiply, round half up and saturating accumulate.
`default_nettype none
module smvm_mac (
  input  logic                     clk,
  input  smvm_pkg::mac_ctrl_t      ctrl,
  input  logic signed [31:0]       a,
  input  logic signed [31:0]       b,
  input  logic signed [31:0]       acc,
  output logic [31:0]              sum,
  output logic                     sat
);

  logic signed [63:0] prod;
  logic signed [47:0] rnd;
  logic signed [48:0] sum_full;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= 64'(a) * 64'(b);
    end
    if (ctrl.rnd_en) begin
      rnd <= 48'((prod + smvm_pkg::ROUND_HALF) >>> 16);
    end
  end

  assign sum_full = 49'(rnd) + 49'(acc);

  always_comb begin
    sat = 1'b0;
    sum = sum_full[31:0];
    if (sum_full > smvm_pkg::SUM_MAX) begin
      sum = smvm_pkg::Q_MAX;
      sat = 1'b1;
    end else if (sum_full < smvm_pkg::SUM_MIN) begin
      sum = smvm_pkg::Q_MIN;
      sat = 1'b1;
    end
  end

endmodule
`default_nettype wire

### src/sparse_matrix_vector_multiply.sv
// Top level of the sparse matrix-vector multiply block.
`default_nettype none
// One request per nonzero or command: load a vector element, clear a row,
// accumulate value * vector[col] into a row (signed Q16.16, round half up,
// saturating) or read a row back; every request gives exactly one result.
// Requests are handled one at a time: each goes through a memory read,
// a registered 32x32 multiply, a rounding stage, the add-and-write-back
// stage and the output load, and a new request is taken once the previous
// one has reached the output register, which waits while a held result
// is not yet taken. After reset the row memory is zeroed one row per
// cycle, during which req_ready is low; register writes are taken at any
// time. row_count sits at byte address 0.
module sparse_matrix_vector_multiply #(
  parameter int MAX_ROWS   = 1024,
  parameter int VECTOR_LEN = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         mode,
  input  logic [9:0]         row,
  input  logic [9:0]         col,
  input  logic signed [31:0] value,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] out_value,
  output logic [9:0]         out_row,
  output logic               range_error,
  output logic               saturated
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int VAW = $clog2(VECTOR_LEN);

  smvm_pkg::state_t   state;
  smvm_pkg::mode_t    item_mode;
  logic [9:0]         item_row;
  logic [9:0]         item_col;
  logic signed [31:0] item_value;
  logic               item_row_ok;
  logic               item_col_ok;
  logic [10:0]        row_count;
  logic [RAW-1:0]     clr_cnt;

  logic [31:0]        res_value;
  logic               res_err;
  logic               res_sat;
  logic [9:0]         res_row;

  logic [31:0]        row_ext;
  logic [31:0]        col_ext;
  logic [RAW-1:0]     acc_addr;
  logic [VAW-1:0]     vec_addr;
  logic               acc_we;
  logic [RAW-1:0]     acc_waddr;
  logic [31:0]        acc_wdata;
  logic [31:0]        acc_rdata;
  logic               vec_we;
  logic [31:0]        vec_rdata;
  logic               req_fire;
  logic               row_ok_in;
  logic               col_ok_in;
  logic [31:0]        mac_sum;
  logic               mac_sat;
  smvm_pkg::mac_ctrl_t mac_ctrl;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == smvm_pkg::REG_ROW_COUNT) ? 32'(row_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= smvm_pkg::ROW_COUNT_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == smvm_pkg::REG_ROW_COUNT) begin
      row_count <= pwdata[10:0];
    end
  end

  assign req_ready = (state == smvm_pkg::S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign row_ok_in = (32'(row) < 32'(row_count)) && (32'(row) < MAX_ROWS);
  assign col_ok_in = 32'(col) < VECTOR_LEN;

  assign row_ext  = 32'(item_row);
  assign col_ext  = 32'(item_col);
  assign acc_addr = row_ext[RAW-1:0];
  assign vec_addr = col_ext[VAW-1:0];

  always_ff @(posedge clk) begin
    if (req_fire) begin
      item_mode   <= smvm_pkg::mode_t'(mode);
      item_row    <= row;
      item_col    <= col;
      item_value  <= value;
      item_row_ok <= row_ok_in;
      item_col_ok <= col_ok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= smvm_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        smvm_pkg::S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == RAW'(MAX_ROWS - 1)) begin
            state <= smvm_pkg::S_IDLE;
          end
        end
        smvm_pkg::S_IDLE: begin
          if (req_fire) begin
            state <= smvm_pkg::S_READ;
          end
        end
        smvm_pkg::S_READ: state <= smvm_pkg::S_MUL;
        smvm_pkg::S_MUL:  state <= smvm_pkg::S_RND;
        smvm_pkg::S_RND:  state <= smvm_pkg::S_ADD;
        smvm_pkg::S_ADD:  state <= smvm_pkg::S_OUT;
        smvm_pkg::S_OUT: begin
          if (!result_valid || result_ready) begin
            state <= smvm_pkg::S_IDLE;
          end
        end
        default: state <= smvm_pkg::S_IDLE;
      endcase
    end
  end

  assign vec_we = (state == smvm_pkg::S_READ) && (item_mode == smvm_pkg::MODE_LOAD)
                  && item_col_ok;

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = acc_addr;
    acc_wdata = '0;
    if (state == smvm_pkg::S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_cnt;
    end else if (state == smvm_pkg::S_READ) begin
      acc_we = (item_mode == smvm_pkg::MODE_CLEAR) && item_row_ok;
    end else if (state == smvm_pkg::S_ADD) begin
      acc_we    = (item_mode == smvm_pkg::MODE_ACC) && item_row_ok && item_col_ok;
      acc_wdata = mac_sum;
    end
  end

  assign mac_ctrl.mul_en = (state == smvm_pkg::S_MUL);
  assign mac_ctrl.rnd_en = (state == smvm_pkg::S_RND);

  smvm_ram #(.WIDTH(32), .DEPTH(VECTOR_LEN)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_addr),
    .wdata (item_value),
    .raddr (vec_addr),
    .rdata (vec_rdata)
  );

  smvm_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_addr),
    .rdata (acc_rdata)
  );

  smvm_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (item_value),
    .b    (vec_rdata),
    .acc  (acc_rdata),
    .sum  (mac_sum),
    .sat  (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (state == smvm_pkg::S_ADD) begin
      unique case (item_mode)
        smvm_pkg::MODE_LOAD: begin
          res_value <= '0;
          res_row   <= '0;
          res_err   <= !item_col_ok;
          res_sat   <= 1'b0;
        end
        smvm_pkg::MODE_CLEAR: begin
          res_value <= '0;
          res_row   <= item_row;
          res_err   <= !item_row_ok;
          res_sat   <= 1'b0;
        end
        smvm_pkg::MODE_ACC: begin
          res_value <= (item_row_ok && item_col_ok) ? mac_sum : '0;
          res_row   <= item_row;
          res_err   <= !(item_row_ok && item_col_ok);
          res_sat   <= item_row_ok && item_col_ok && mac_sat;
        end
        smvm_pkg::MODE_READ: begin
          res_value <= item_row_ok ? acc_rdata : '0;
          res_row   <= item_row;
          res_err   <= !item_row_ok;
          res_sat   <= 1'b0;
        end
        default: begin
          res_value <= '0;
          res_row   <= item_row;
          res_err   <= 1'b1;
          res_sat   <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == smvm_pkg::S_OUT && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == smvm_pkg::S_OUT && (!result_valid || result_ready)) begin
      out_value   <= res_value;
      out_row     <= res_row;
      range_error <= res_err;
      saturated   <= res_sat;
    end
  end

`ifndef SYNTHESIS
  a_req_starts_read: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == smvm_pkg::S_READ)
    else $error("accepted request did not start a memory read");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == smvm_pkg::S_IDLE |-> !acc_we && !vec_we)
    else $error("memory written while idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && range_error |-> out_value == 0 && !saturated)
    else $error("flagged result carries data");

  a_vec_write_ok: assert property (@(posedge clk) disable iff (rst)
    vec_we |-> item_col_ok && item_mode == smvm_pkg::MODE_LOAD)
    else $error("vector written by an invalid request");
`endif

endmodule
`default_nettype wire
